// ===== hdl/v210u_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the v210 to 8-bit UYVY unpacker
package v210u_pkg;

  // Geometry limits
  localparam int MAX_LUMA_WIDTH = 4096;
  localparam int MAX_PAIRS      = MAX_LUMA_WIDTH / 2;
  localparam int MAX_LINES      = 4096;

  // Field and counter widths
  localparam int PAIRS_W      = 12;  // line_pixel_pairs register
  localparam int LINES_W      = 13;  // lines_per_frame register
  localparam int WORD_IDX_W   = 12;  // word index within a line
  localparam int LINE_IDX_W   = 12;  // line index within a frame
  localparam int POS_W        = 14;  // sample index within a line
  localparam int SAMPLE_W     = 8;
  localparam int SAMPLES_PER_WORD = 3;
  localparam int CNT_W        = 2;   // samples per word, 0..3
  localparam int WORD_W       = 32;
  localparam int SRC_SAMPLE_W = 10;
  localparam int DROP_BITS    = 2;

  // v210 groups: 24 pixel pairs occupy 32 words
  localparam int GROUP_PAIRS  = 24;
  localparam int GROUP_WORDS  = 32;
  localparam int GROUP_SHIFT  = 5;   // log2 of GROUP_WORDS
  // ceil(p/24) = ((p+23)>>3) / 3, divide by 3 through 171/512
  localparam int RECIP3       = 171;
  localparam int RECIP3_W     = 8;
  localparam int RECIP3_SHIFT = 9;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LINE_PIXEL_PAIRS = 1'b0;
  localparam logic REG_LINES_PER_FRAME  = 1'b1;

  // Reset values and the geometry they imply
  localparam int RST_PAIRS  = 960;
  localparam int RST_LINES  = 1080;
  localparam int RST_ACTIVE = 4 * RST_PAIRS;
  localparam int RST_WORDS  = ((RST_PAIRS + GROUP_PAIRS - 1) / GROUP_PAIRS) * GROUP_WORDS;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Effective line and frame geometry
  typedef struct packed {
    logic [POS_W-1:0]      active;  // active samples per line
    logic [WORD_IDX_W-1:0] words;   // words per line, padding included
    logic [LINES_W-1:0]    lines;   // lines per frame
  } geom_t;

  // One classified word: its active samples are always a prefix
  typedef struct packed {
    logic [SAMPLES_PER_WORD-1:0][SAMPLE_W-1:0] samples;
    logic [CNT_W-1:0] count;      // 1..3
    logic             line_end;   // last sample closes the line
    logic             frame_end;  // last sample closes the frame
  } entry_t;

endpackage

// ===== hdl/v210u_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers and the derived line geometry
module v210u_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [v210u_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [v210u_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [v210u_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready,
  output v210u_pkg::geom_t                     geom
);

  logic [v210u_pkg::PAIRS_W-1:0] pairs_r;
  logic [v210u_pkg::LINES_W-1:0] lines_r;
  v210u_pkg::geom_t              geom_r, geom_nxt;

  logic                          reg_sel;
  logic                          wr_en;
  logic [v210u_pkg::PAIRS_W-1:0] eff_pairs;
  logic [v210u_pkg::LINES_W-1:0] eff_lines;
  logic [v210u_pkg::PAIRS_W-1:0] pairs_ceil;
  logic [v210u_pkg::RECIP3_SHIFT-1:0] eighths;
  logic [v210u_pkg::RECIP3_SHIFT+v210u_pkg::RECIP3_W-1:0] prod;
  logic [v210u_pkg::WORD_IDX_W-v210u_pkg::GROUP_SHIFT-1:0] groups;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= v210u_pkg::PAIRS_W'(v210u_pkg::RST_PAIRS);
      lines_r <= v210u_pkg::LINES_W'(v210u_pkg::RST_LINES);
    end else if (wr_en) begin
      case (reg_sel)
        v210u_pkg::REG_LINE_PIXEL_PAIRS: pairs_r <= pwdata[v210u_pkg::PAIRS_W-1:0];
        v210u_pkg::REG_LINES_PER_FRAME:  lines_r <= pwdata[v210u_pkg::LINES_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      v210u_pkg::REG_LINE_PIXEL_PAIRS:
        prdata = v210u_pkg::CFG_DATA_W'(pairs_r);
      v210u_pkg::REG_LINES_PER_FRAME:
        prdata = v210u_pkg::CFG_DATA_W'(lines_r);
      default: prdata = '0;
    endcase
  end

  // Clamp width and height, then derive line length in words
  always_comb begin
    if (pairs_r == '0)
      eff_pairs = v210u_pkg::PAIRS_W'(1);
    else if (pairs_r > v210u_pkg::PAIRS_W'(v210u_pkg::MAX_PAIRS))
      eff_pairs = v210u_pkg::PAIRS_W'(v210u_pkg::MAX_PAIRS);
    else
      eff_pairs = pairs_r;

    if (lines_r == '0)
      eff_lines = v210u_pkg::LINES_W'(1);
    else if (lines_r > v210u_pkg::LINES_W'(v210u_pkg::MAX_LINES))
      eff_lines = v210u_pkg::LINES_W'(v210u_pkg::MAX_LINES);
    else
      eff_lines = lines_r;

    // groups = ceil(pairs / 24)
    pairs_ceil = eff_pairs + v210u_pkg::PAIRS_W'(v210u_pkg::GROUP_PAIRS - 1);
    eighths    = v210u_pkg::RECIP3_SHIFT'(pairs_ceil >> 3);
    prod       = eighths * v210u_pkg::RECIP3_W'(v210u_pkg::RECIP3);
    groups     = prod[v210u_pkg::RECIP3_SHIFT +: (v210u_pkg::WORD_IDX_W-v210u_pkg::GROUP_SHIFT)];

    geom_nxt.active = {eff_pairs, 2'b00};
    geom_nxt.words  = {groups, {v210u_pkg::GROUP_SHIFT{1'b0}}};
    geom_nxt.lines  = eff_lines;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.active <= v210u_pkg::POS_W'(v210u_pkg::RST_ACTIVE);
      geom_r.words  <= v210u_pkg::WORD_IDX_W'(v210u_pkg::RST_WORDS);
      geom_r.lines  <= v210u_pkg::LINES_W'(v210u_pkg::RST_LINES);
    end else begin
      geom_r <= geom_nxt;
    end
  end

  assign geom = geom_r;

endmodule

// ===== hdl/v210u_front.sv =====
`timescale 1ns / 1ps
// Front end: takes words, tracks position in line and frame, classifies samples
module v210u_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  v210u_pkg::geom_t                 geom,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [v210u_pkg::WORD_W-1:0]     in_tdata,
  input  logic                             q_full,
  output logic                             q_push,
  output v210u_pkg::entry_t                q_data
);

  logic [v210u_pkg::WORD_IDX_W-1:0] word_idx_r, word_idx_nxt;
  logic [v210u_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [v210u_pkg::LINE_IDX_W-1:0] line_idx_r, line_idx_nxt;

  logic                             accept;
  logic                             last_line;
  logic                             line_done;
  logic                             any_active;
  logic [v210u_pkg::POS_W-1:0]      remain;
  logic [v210u_pkg::CNT_W-1:0]      count;

  assign in_tready = !q_full;
  assign accept    = in_tvalid & in_tready;

  // Classify the word against the line geometry
  always_comb begin
    last_line  = ({1'b0, line_idx_r} + v210u_pkg::LINES_W'(1)) >= geom.lines;
    line_done  = ({1'b0, word_idx_r} + 13'd1) >= {1'b0, geom.words};
    any_active = geom.active > pos_r;
    remain     = geom.active - pos_r;
    if (!any_active)
      count = '0;
    else if (remain >= v210u_pkg::POS_W'(v210u_pkg::SAMPLES_PER_WORD))
      count = v210u_pkg::CNT_W'(v210u_pkg::SAMPLES_PER_WORD);
    else
      count = remain[v210u_pkg::CNT_W-1:0];

    for (int k = 0; k < v210u_pkg::SAMPLES_PER_WORD; k++) begin
      q_data.samples[k] = in_tdata[k*v210u_pkg::SRC_SAMPLE_W + v210u_pkg::DROP_BITS +:
                                   v210u_pkg::SAMPLE_W];
    end
    q_data.count     = count;
    q_data.line_end  = any_active &&
                       (remain <= v210u_pkg::POS_W'(v210u_pkg::SAMPLES_PER_WORD));
    q_data.frame_end = q_data.line_end && last_line;
    q_push           = accept && (count != '0);
  end

  // Position counters
  always_comb begin
    word_idx_nxt = word_idx_r;
    pos_nxt      = pos_r;
    line_idx_nxt = line_idx_r;
    if (accept) begin
      if (line_done) begin
        word_idx_nxt = '0;
        pos_nxt      = '0;
        line_idx_nxt = last_line ? '0 : line_idx_r + v210u_pkg::LINE_IDX_W'(1);
      end else begin
        word_idx_nxt = word_idx_r + v210u_pkg::WORD_IDX_W'(1);
        pos_nxt      = pos_r + v210u_pkg::POS_W'(v210u_pkg::SAMPLES_PER_WORD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_idx_r <= '0;
      pos_r      <= '0;
      line_idx_r <= '0;
    end else begin
      word_idx_r <= word_idx_nxt;
      pos_r      <= pos_nxt;
      line_idx_r <= line_idx_nxt;
    end
  end

endmodule

// ===== hdl/v210u_queue.sv =====
`timescale 1ns / 1ps
// Small queue of classified words between front and back
module v210u_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  v210u_pkg::entry_t push_data,
  output logic              full,
  input  logic              pop,
  output v210u_pkg::entry_t head,
  output logic              empty
);

  v210u_pkg::entry_t                 mem_r [v210u_pkg::QUEUE_DEPTH];
  logic [v210u_pkg::QUEUE_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [v210u_pkg::QUEUE_AW:0]      fill_r, fill_nxt;
  logic                              do_push, do_pop;

  assign full    = fill_r == (v210u_pkg::QUEUE_AW+1)'(v210u_pkg::QUEUE_DEPTH);
  assign empty   = fill_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (do_push && !do_pop)
      fill_nxt = fill_r + (v210u_pkg::QUEUE_AW+1)'(1);
    else if (do_pop && !do_push)
      fill_nxt = fill_r - (v210u_pkg::QUEUE_AW+1)'(1);
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= push_data;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= wr_ptr_r + v210u_pkg::QUEUE_AW'(1);
      if (do_pop)
        rd_ptr_r <= rd_ptr_r + v210u_pkg::QUEUE_AW'(1);
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== hdl/v210u_back.sv =====
`timescale 1ns / 1ps
// Back end: serializes queued words, one beat per cycle unless stalled
module v210u_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  v210u_pkg::entry_t                  head,
  input  logic                               q_empty,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [v210u_pkg::SAMPLE_W-1:0]     out_tdata,
  output logic                               out_tlast,
  output logic [1:0]                         out_tuser
);

  logic [v210u_pkg::CNT_W-1:0]    sel_r, sel_nxt;
  logic                           valid_r, valid_nxt;
  logic [v210u_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                           word_last_r, word_last_nxt;
  logic                           line_end_r, line_end_nxt;
  logic                           frame_end_r, frame_end_nxt;
  logic                           load;
  logic                           is_last;

  assign load    = !valid_r || out_tready;
  assign is_last = sel_r == (head.count - v210u_pkg::CNT_W'(1));
  assign q_pop   = load && !q_empty && is_last;

  always_comb begin
    sel_nxt       = sel_r;
    valid_nxt     = valid_r;
    sample_nxt    = sample_r;
    word_last_nxt = word_last_r;
    line_end_nxt  = line_end_r;
    frame_end_nxt = frame_end_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        case (sel_r)
          2'd0:    sample_nxt = head.samples[0];
          2'd1:    sample_nxt = head.samples[1];
          default: sample_nxt = head.samples[2];
        endcase
        word_last_nxt = is_last;
        line_end_nxt  = is_last && head.line_end;
        frame_end_nxt = is_last && head.frame_end;
        sel_nxt       = is_last ? '0 : sel_r + v210u_pkg::CNT_W'(1);
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    word_last_r <= word_last_nxt;
    line_end_r  <= line_end_nxt;
    frame_end_r <= frame_end_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = sample_r;
  assign out_tlast  = line_end_r;
  assign out_tuser  = {frame_end_r, word_last_r};

endmodule

// ===== hdl/v210_to_uyvy8_unpacker.sv =====
`timescale 1ns / 1ps
// v210 to 8-bit UYVY unpacker. Each input beat is one little-endian v210 word
// carrying three 10-bit samples (bits 9:0, 19:10, 29:20); each becomes an 8-bit
// sample (top eight bits) on the output, one beat per cycle while out_tready
// is high, so a word with three active samples yields three output beats and
// the output side rather than the input limits the sustained rate. Samples
// past 4*line_pixel_pairs and the padding words of each line (32 words per 24
// pixel pairs, rounded up) produce no beats. out_tlast marks the last active
// sample of a line; out_tuser[0] marks the last beat of a word and out_tuser[1]
// the last active sample of a frame. A 4-deep queue between the word
// classifier and the output serializer lets the input run ahead while output
// is stalled. Width is capped at 2048 pixel pairs and height at 4096 lines;
// zero acts as one. Write configuration only while the block is idle; new
// geometry reaches words through the cfg registers and then the geom_r register.
module v210_to_uyvy8_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] packed_word
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] sample
  output logic        out_tlast,   // line_end
  output logic [1:0]  out_tuser,   // [0] word_last, [1] frame_end
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  v210u_pkg::geom_t  geom;
  v210u_pkg::entry_t push_data;
  v210u_pkg::entry_t head;
  logic              q_push, q_full, q_pop, q_empty;

  v210u_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .geom    (geom)
  );

  v210u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  v210u_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  v210u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
